### sv/crtess_pkg.sv
// shared types and constants of the catmull-rom tessellator
`default_nettype none

package crtess_pkg;

  localparam int COORD_BITS_DEF  = 24;
  localparam int MAX_SAMPLES_DEF = 32;

  localparam int              CFG_W     = 6;
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS,
    ST_SETUP1,
    ST_SETUP2,
    ST_SETUP3,
    ST_H0,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_DIV_LOAD,
    ST_DIV,
    ST_EMIT
  } ctrl_state_t;

  // which window entries feed P0..P3 of a segment (entry 0 is the newest point)
  typedef enum logic [1:0] {
    SEG_OPEN,        // 2,2,1,0 : first segment, start clamped
    SEG_MID,         // 3,2,1,0
    SEG_CLOSE_SHORT, // 1,1,0,0 : two-point curve
    SEG_CLOSE        // 2,1,0,0 : last segment, end clamped
  } seg_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_SETUP1,
    DP_SETUP2,
    DP_SETUP3,
    DP_H0,
    DP_H1,
    DP_H2,
    DP_H3,
    DP_DIV_LOAD,
    DP_DIV_STEP,
    DP_OUT_PASS,
    DP_OUT_SAMPLE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    seg_t   seg;
  } dp_cmd_t;

  typedef struct packed {
    logic sample_last;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

### sv/crtess_dp.sv
// datapath: point window, cubic evaluation lanes, restoring dividers, output registers
`default_nettype none

module crtess_dp #(
  parameter int COORD_BITS  = crtess_pkg::COORD_BITS_DEF,
  parameter int MAX_SAMPLES = crtess_pkg::MAX_SAMPLES_DEF
) (
  input  logic                              clk,
  input  crtess_pkg::dp_cmd_t               cmd,
  output crtess_pkg::dp_status_t            status,
  input  logic [crtess_pkg::CFG_W-1:0]      cfg_samples,
  input  logic signed [COORD_BITS-1:0]      in_point_x,
  input  logic signed [COORD_BITS-1:0]      in_point_y,
  input  logic signed [COORD_BITS-1:0]      in_point_z,
  output logic signed [COORD_BITS-1:0]      sample_x,
  output logic signed [COORD_BITS-1:0]      sample_y,
  output logic signed [COORD_BITS-1:0]      sample_z
);
  import crtess_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int NW   = $clog2(MAX_SAMPLES + 1);
  localparam int N2W  = 2 * NW;
  localparam int N3W  = 3 * NW;
  localparam int KW   = CB + 4;           // cubic coefficients
  localparam int HW   = CB + 5 + N3W;     // scaled numerator
  localparam int QB   = CB + 1;           // quotient magnitude bits
  localparam int CNTW = $clog2(QB);

  localparam logic [CFG_W-1:0]     MAX_CFG = CFG_W'(MAX_SAMPLES);
  localparam logic signed [CB+1:0] SAT_HI  = {3'b000, {(CB-1){1'b1}}};
  localparam logic signed [CB+1:0] SAT_LO  = {3'b111, {(CB-1){1'b0}}};

  // window entry 0 is the newest point, one lane per axis
  logic signed [CB-1:0]   win_r [4][3];
  logic signed [CB-1:0]   pin   [3];

  logic [NW-1:0]          n_c;
  logic [NW-1:0]          n_r;
  logic [N2W-1:0]         n2_r;
  logic [N3W-1:0]         n3_r;
  logic [NW-1:0]          s_r;

  logic signed [CB-1:0]   pt0 [3];
  logic signed [CB-1:0]   pt1 [3];
  logic signed [CB-1:0]   pt2 [3];
  logic signed [CB-1:0]   pt3 [3];
  logic signed [KW-1:0]   ext0 [3];
  logic signed [KW-1:0]   ext1 [3];
  logic signed [KW-1:0]   ext2 [3];
  logic signed [KW-1:0]   ext3 [3];
  logic signed [KW-1:0]   a_c [3];
  logic signed [KW-1:0]   b_c [3];
  logic signed [KW-1:0]   c_c [3];

  logic signed [KW-1:0]   a_r  [3];
  logic signed [KW-1:0]   b_r  [3];
  logic signed [KW-1:0]   c_r  [3];
  logic signed [CB-1:0]   p1_r [3];

  logic signed [KW+N2W:0] an2_c [3];
  logic signed [KW+NW:0]  bn_c  [3];
  logic signed [CB+N3W:0] pn3_c [3];
  logic signed [HW-1:0]   an2_r [3];
  logic signed [HW-1:0]   bn_r  [3];
  logic signed [HW-1:0]   cst_r [3];   // 2*p1*n^3 plus the rounding half n^3

  logic signed [NW:0]     s_sig;
  logic signed [HW-1:0]   mul_in  [3];
  logic signed [HW+NW:0]  mul_out [3];
  logic signed [HW-1:0]   h_r [3];

  logic [HW-1:0]          rem_r [3];
  logic [HW-1:0]          d_r   [3];
  logic [HW:0]            diff  [3];
  logic [QB-1:0]          q_r   [3];
  logic                   neg_r [3];
  logic [CNTW-1:0]        cnt_r;

  logic [CB+1:0]          q_u  [3];
  logic signed [CB+1:0]   q_s  [3];
  logic signed [CB-1:0]   sat  [3];
  logic signed [CB-1:0]   out_r [3];

  assign pin[0] = in_point_x;
  assign pin[1] = in_point_y;
  assign pin[2] = in_point_z;

  // clamp of the sample count
  always_comb begin
    if (cfg_samples < CFG_W'(2)) begin
      n_c = NW'(2);
    end else if (cfg_samples > MAX_CFG) begin
      n_c = NW'(MAX_SAMPLES);
    end else begin
      n_c = cfg_samples[NW-1:0];
    end
  end

  // segment control points and cubic coefficients
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (cmd.seg)
        SEG_OPEN: begin
          pt0[i] = win_r[2][i]; pt1[i] = win_r[2][i];
          pt2[i] = win_r[1][i]; pt3[i] = win_r[0][i];
        end
        SEG_MID: begin
          pt0[i] = win_r[3][i]; pt1[i] = win_r[2][i];
          pt2[i] = win_r[1][i]; pt3[i] = win_r[0][i];
        end
        SEG_CLOSE_SHORT: begin
          pt0[i] = win_r[1][i]; pt1[i] = win_r[1][i];
          pt2[i] = win_r[0][i]; pt3[i] = win_r[0][i];
        end
        SEG_CLOSE: begin
          pt0[i] = win_r[2][i]; pt1[i] = win_r[1][i];
          pt2[i] = win_r[0][i]; pt3[i] = win_r[0][i];
        end
        default: begin
          pt0[i] = win_r[2][i]; pt1[i] = win_r[1][i];
          pt2[i] = win_r[0][i]; pt3[i] = win_r[0][i];
        end
      endcase
      ext0[i] = KW'(pt0[i]);
      ext1[i] = KW'(pt1[i]);
      ext2[i] = KW'(pt2[i]);
      ext3[i] = KW'(pt3[i]);
      a_c[i] = ext2[i] - ext0[i];
      b_c[i] = (ext0[i] <<< 1) - (ext1[i] <<< 2) - ext1[i] + (ext2[i] <<< 2) - ext3[i];
      c_c[i] = (ext1[i] <<< 1) + ext1[i] - (ext2[i] <<< 1) - ext2[i] + ext3[i] - ext0[i];
    end
  end

  // per-segment scale products and the shared horner multiplier of each lane
  assign s_sig = $signed({1'b0, s_r});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      an2_c[i] = (KW+N2W+1)'(a_r[i]) * (KW+N2W+1)'($signed({1'b0, n2_r}));
      bn_c[i]  = (KW+NW+1)'(b_r[i]) * (KW+NW+1)'($signed({1'b0, n_r}));
      pn3_c[i] = (CB+N3W+1)'(p1_r[i]) * (CB+N3W+1)'($signed({1'b0, n3_r}));
      priority case (cmd.op)
        DP_H1:   mul_in[i] = h_r[i] + bn_r[i];
        DP_H2:   mul_in[i] = h_r[i] + an2_r[i];
        default: mul_in[i] = HW'(c_r[i]);
      endcase
      mul_out[i] = (HW+NW+1)'(mul_in[i]) * (HW+NW+1)'(s_sig);
      diff[i]    = {1'b0, rem_r[i]} - {1'b0, d_r[i]};
    end
  end

  // floor quotient with sign, then saturation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (neg_r[i]) begin
        q_u[i] = ~{1'b0, q_r[i]} + (CB+2)'(rem_r[i] == '0);
      end else begin
        q_u[i] = {1'b0, q_r[i]};
      end
      q_s[i] = $signed(q_u[i]);
      if (q_s[i] > SAT_HI) begin
        sat[i] = SAT_HI[CB-1:0];
      end else if (q_s[i] < SAT_LO) begin
        sat[i] = SAT_LO[CB-1:0];
      end else begin
        sat[i] = q_s[i][CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          win_r[3][i] <= win_r[2][i];
          win_r[2][i] <= win_r[1][i];
          win_r[1][i] <= win_r[0][i];
          win_r[0][i] <= pin[i];
        end
      end
      DP_SETUP1: begin
        n_r  <= n_c;
        n2_r <= N2W'(n_c) * N2W'(n_c);
        for (int i = 0; i < 3; i++) begin
          a_r[i]  <= a_c[i];
          b_r[i]  <= b_c[i];
          c_r[i]  <= c_c[i];
          p1_r[i] <= pt1[i];
        end
      end
      DP_SETUP2: begin
        n3_r <= N3W'(n2_r) * N3W'(n_r);
        for (int i = 0; i < 3; i++) begin
          an2_r[i] <= HW'(an2_c[i]);
          bn_r[i]  <= HW'(bn_c[i]);
        end
      end
      DP_SETUP3: begin
        s_r <= NW'(1);
        for (int i = 0; i < 3; i++) begin
          cst_r[i] <= (HW'(pn3_c[i]) <<< 1) + $signed({{(HW-N3W){1'b0}}, n3_r});
        end
      end
      DP_H0, DP_H1, DP_H2: begin
        for (int i = 0; i < 3; i++) begin
          h_r[i] <= $signed(mul_out[i][HW-1:0]);
        end
      end
      DP_H3: begin
        for (int i = 0; i < 3; i++) begin
          h_r[i] <= h_r[i] + cst_r[i];
        end
      end
      DP_DIV_LOAD: begin
        cnt_r <= CNTW'(QB - 1);
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= h_r[i][HW-1];
          rem_r[i] <= h_r[i][HW-1] ? $unsigned(-h_r[i]) : $unsigned(h_r[i]);
          d_r[i]   <= {{(HW-N3W-1){1'b0}}, n3_r, 1'b0} << (QB - 1);
          q_r[i]   <= '0;
        end
      end
      DP_DIV_STEP: begin
        cnt_r <= cnt_r - CNTW'(1);
        for (int i = 0; i < 3; i++) begin
          if (!diff[i][HW]) begin
            rem_r[i] <= diff[i][HW-1:0];
            q_r[i]   <= {q_r[i][QB-2:0], 1'b1};
          end else begin
            q_r[i]   <= {q_r[i][QB-2:0], 1'b0};
          end
          d_r[i] <= d_r[i] >> 1;
        end
      end
      DP_OUT_PASS: begin
        for (int i = 0; i < 3; i++) begin
          out_r[i] <= win_r[0][i];
        end
      end
      DP_OUT_SAMPLE: begin
        s_r <= s_r + NW'(1);
        for (int i = 0; i < 3; i++) begin
          out_r[i] <= sat[i];
        end
      end
      default: begin
      end
    endcase
  end

  assign status.sample_last = (s_r == n_r);
  assign status.div_last    = (cnt_r == '0);

  assign sample_x = out_r[0];
  assign sample_y = out_r[1];
  assign sample_z = out_r[2];

endmodule

`default_nettype wire

### sv/crtess_ctrl.sv
// controller: curve sequencing, sample and division steps, output handshake
`default_nettype none

module crtess_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_final_point,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_run_end,
  output logic                   out_curve_end,
  output crtess_pkg::dp_cmd_t    cmd,
  input  crtess_pkg::dp_status_t status
);
  import crtess_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic        fin_r, fin_nxt;
  logic        second_r, second_nxt;
  seg_t        seg_r, seg_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        run_end_r, run_end_nxt;
  logic        curve_end_r, curve_end_nxt;

  logic        in_accept;
  logic        out_free;
  logic        out_load;
  logic        last_run;

  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= 2'd0;
      fin_r       <= 1'b0;
      second_r    <= 1'b0;
      seg_r       <= SEG_OPEN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      fin_r       <= fin_nxt;
      second_r    <= second_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_end_r   <= run_end_nxt;
    curve_end_r <= curve_end_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    fin_nxt       = fin_r;
    second_nxt    = second_r;
    seg_nxt       = seg_r;
    run_end_nxt   = run_end_r;
    curve_end_nxt = curve_end_r;
    out_load      = 1'b0;
    last_run      = 1'b0;
    cmd.op        = DP_IDLE;
    cmd.seg       = seg_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          cmd.op  = DP_LOAD;
          fin_nxt = in_final_point;
          if (in_final_point) begin
            seen_nxt = 2'd0;
          end else if (seen_r != 2'd3) begin
            seen_nxt = seen_r + 2'd1;
          end
          priority if (seen_r == 2'd0) begin
            state_nxt = ST_PASS;
          end else if (seen_r == 2'd1) begin
            // second point only closes a segment when it ends the curve
            if (in_final_point) begin
              seg_nxt    = SEG_CLOSE_SHORT;
              second_nxt = 1'b0;
              state_nxt  = ST_SETUP1;
            end
          end else begin
            seg_nxt    = (seen_r == 2'd3) ? SEG_MID : SEG_OPEN;
            second_nxt = in_final_point;
            state_nxt  = ST_SETUP1;
          end
        end
      end
      ST_PASS: begin
        if (out_free) begin
          cmd.op        = DP_OUT_PASS;
          out_load      = 1'b1;
          run_end_nxt   = 1'b1;
          curve_end_nxt = fin_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SETUP1: begin
        cmd.op    = DP_SETUP1;
        state_nxt = ST_SETUP2;
      end
      ST_SETUP2: begin
        cmd.op    = DP_SETUP2;
        state_nxt = ST_SETUP3;
      end
      ST_SETUP3: begin
        cmd.op    = DP_SETUP3;
        state_nxt = ST_H0;
      end
      ST_H0: begin
        cmd.op    = DP_H0;
        state_nxt = ST_H1;
      end
      ST_H1: begin
        cmd.op    = DP_H1;
        state_nxt = ST_H2;
      end
      ST_H2: begin
        cmd.op    = DP_H2;
        state_nxt = ST_H3;
      end
      ST_H3: begin
        cmd.op    = DP_H3;
        state_nxt = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.op    = DP_DIV_LOAD;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = DP_DIV_STEP;
        if (status.div_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.op        = DP_OUT_SAMPLE;
          out_load      = 1'b1;
          last_run      = status.sample_last && !second_r;
          run_end_nxt   = last_run;
          curve_end_nxt = last_run && fin_r;
          if (!status.sample_last) begin
            state_nxt = ST_H0;
          end else if (second_r) begin
            // closing point: clamped end segment follows
            second_nxt = 1'b0;
            seg_nxt    = SEG_CLOSE;
            state_nxt  = ST_SETUP1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_run_end   = run_end_r;
  assign out_curve_end = curve_end_r;

endmodule

`default_nettype wire

### sv/catmull_rom_curve_tessellator_core.sv
// Uniform Catmull-Rom curve tessellator, top level. Control points enter one item at a time
// on the in_ channel (valid/stall) with the last point of a curve marked; samples leave on the
// out_ channel through a one-entry output register, so a finished sample waits there while the
// block works on. Items are processed one at a time. The first point of a curve goes to the
// output via the pass state once the output register is free, and the input is free again
// in the same cycle as that point is offered. After it is taken, a point that closes a segment
// holds the input through the setup states SETUP1 to SETUP3 and n samples (n the clamped
// sample count) plus any wait of a finished sample for the output register to empty; the final
// point of a curve of three or more points runs two segments, each with its own setup states.
// Each sample runs Horner evaluation on a shared multiplier, a load step, the exact rounding
// division (a restoring divider per axis that resolves one quotient bit per cycle over
// COORD_BITS+1 steps) and an output step. A second point that does not end the curve
// produces nothing and is absorbed without leaving the idle state. The user must write
// samples_per_segment via cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
`default_nettype none

module catmull_rom_curve_tessellator_core #(
  parameter int COORD_BITS  = crtess_pkg::COORD_BITS_DEF,
  parameter int MAX_SAMPLES = crtess_pkg::MAX_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [crtess_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_point_x,
  input  logic signed [COORD_BITS-1:0]  in_point_y,
  input  logic signed [COORD_BITS-1:0]  in_point_z,
  input  logic                          in_final_point,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  out_sample_x,
  output logic signed [COORD_BITS-1:0]  out_sample_y,
  output logic signed [COORD_BITS-1:0]  out_sample_z,
  output logic                          out_run_end,
  output logic                          out_curve_end
);
  import crtess_pkg::*;

  logic [CFG_W-1:0] samples_r;
  dp_cmd_t          cmd;
  dp_status_t       status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      samples_r <= cfg_wr_data;
    end
  end

  crtess_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_final_point (in_final_point),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_run_end    (out_run_end),
    .out_curve_end  (out_curve_end),
    .cmd            (cmd),
    .status         (status)
  );

  crtess_dp #(
    .COORD_BITS  (COORD_BITS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .cfg_samples (samples_r),
    .in_point_x  (in_point_x),
    .in_point_y  (in_point_y),
    .in_point_z  (in_point_z),
    .sample_x    (out_sample_x),
    .sample_y    (out_sample_y),
    .sample_z    (out_sample_z)
  );

endmodule

`default_nettype wire

### sv/crtess_checker.sv
// port-level checks of the tessellator and their bind to the top level
`default_nettype none

module crtess_checker #(
  parameter int COORD_BITS = crtess_pkg::COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [COORD_BITS-1:0] out_sample_x,
  input logic signed [COORD_BITS-1:0] out_sample_y,
  input logic signed [COORD_BITS-1:0] out_sample_z,
  input logic                         out_run_end,
  input logic                         out_curve_end
);

  // a waiting sample keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_x) &&
      $stable(out_sample_y) && $stable(out_sample_z) &&
      $stable(out_run_end) && $stable(out_curve_end))
    else $error("stalled output item changed");

  // the end of a curve is always the end of its point's run
  a_curve_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_run_end || !out_curve_end))
    else $error("curve_end without run_end");

  // more samples of the same point still to come: no new item may be taken
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_run_end |-> in_stall)
    else $error("input taken in the middle of a run");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // input side is held off during reset
  a_reset_stall: assert property (@(posedge clk)
    !rst_n |-> in_stall || !in_valid)
    else $error("input accepted during reset");

endmodule

bind catmull_rom_curve_tessellator_core crtess_checker #(
  .COORD_BITS (COORD_BITS)
) u_crtess_checker (.*);

`default_nettype wire

### sim/tb_top.sv
// testbench for the catmull-rom curve tessellator core
`timescale 1ns / 100ps

module tb_top;
  import crtess_pkg::*;

  localparam int W            = COORD_BITS_DEF;
  localparam int MAX_N        = MAX_SAMPLES_DEF;
  localparam int RANDOM_ITEMS = 335;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int MAX_REPORTS   = 10;

  typedef logic signed [W-1:0] coord_t;

  localparam coord_t C_MAX = {1'b0, {(W-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   run_end;
    logic   curve_end;
  } sample_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  coord_t           in_point_x = '0;
  coord_t           in_point_y = '0;
  coord_t           in_point_z = '0;
  logic             in_final_point = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  coord_t           out_sample_x;
  coord_t           out_sample_y;
  coord_t           out_sample_z;
  logic             out_run_end;
  logic             out_curve_end;

  // predictor state
  logic [CFG_W-1:0] sample_count = CFG_RESET;
  point_t           history [3];
  logic [1:0]       points_in_curve = 2'd0;
  sample_t          pending_samples [$];

  int  mismatch_count = 0;
  int  hold_cycles = 0;
  bit  no_gaps = 1'b0;
  int  cycle_count = 0;

  catmull_rom_curve_tessellator_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .in_final_point(in_final_point),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_x  (out_sample_x),
    .out_sample_y  (out_sample_y),
    .out_sample_z  (out_sample_z),
    .out_run_end   (out_run_end),
    .out_curve_end (out_curve_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // exact rounded evaluation of one axis at t = s/n, halves toward +inf, saturated
  function automatic coord_t spline_axis(coord_t c0, coord_t c1, coord_t c2, coord_t c3,
                                         longint s, longint n);
    longint p0, p1, p2, p3, a, b, c, n3, num, den, x, q, hi, lo;
    p0 = c0;
    p1 = c1;
    p2 = c2;
    p3 = c3;
    a = p2 - p0;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c = -p0 + 3 * p1 - 3 * p2 + p3;
    n3 = n * n * n;
    num = 2 * p1 * n3 + a * s * n * n + b * s * s * n + c * s * s * s;
    den = 2 * n3;
    x = num + n3;
    if (x >= 0) q = x / den;
    else q = -((-x + den - 1) / den);
    hi = (longint'(1) << (W - 1)) - 1;
    lo = -hi - 1;
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q[W-1:0];
  endfunction

  task automatic add_segment(ref sample_t batch[$], input point_t p0, input point_t p1,
                             input point_t p2, input point_t p3, input int n);
    sample_t smp;
    for (int s = 1; s <= n; s++) begin
      smp = '0;
      smp.x = spline_axis(p0.x, p1.x, p2.x, p3.x, s, n);
      smp.y = spline_axis(p0.y, p1.y, p2.y, p3.y, s, n);
      smp.z = spline_axis(p0.z, p1.z, p2.z, p3.z, s, n);
      batch.push_back(smp);
    end
  endtask

  // samples caused by one accepted control point
  task automatic tessellate_point(point_t p, bit fin);
    sample_t batch [$];
    sample_t smp;
    int      n;
    n = sample_count;
    if (n < 2) n = 2;
    if (n > MAX_N) n = MAX_N;
    case (points_in_curve)
      2'd0: begin
        smp = '0;
        smp.x = p.x;
        smp.y = p.y;
        smp.z = p.z;
        batch.push_back(smp);
      end
      2'd1: begin
        if (fin) add_segment(batch, history[0], history[0], p, p, n);
      end
      default: begin
        // start of the curve is clamped until a fourth point is known
        add_segment(batch, (points_in_curve == 2'd3) ? history[2] : history[1],
                    history[1], history[0], p, n);
        if (fin) add_segment(batch, history[1], history[0], p, p, n);
      end
    endcase
    if (batch.size() > 0) begin
      batch[batch.size()-1].run_end = 1'b1;
      batch[batch.size()-1].curve_end = fin;
    end
    foreach (batch[i]) pending_samples.push_back(batch[i]);
    history[2] = history[1];
    history[1] = history[0];
    history[0] = p;
    if (fin) points_in_curve = 2'd0;
    else if (points_in_curve != 2'd3) points_in_curve = points_in_curve + 2'd1;
  endtask

  function automatic point_t mk_point(coord_t x, coord_t y, coord_t z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 15))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      3: return '1;
      default: return coord_t'($urandom());
    endcase
  endfunction

  task automatic send_point(point_t p, bit fin);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_point_x     <= p.x;
    in_point_y     <= p.y;
    in_point_z     <= p.z;
    in_final_point <= fin;
    do @(posedge clk); while (in_stall);
    tessellate_point(p, fin);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // stop offering items and let every expected sample come out
  task automatic wait_drained();
    idle_input();
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sample_count(logic [CFG_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sample_count = value;
  endtask

  function automatic void check_sample();
    sample_t got, want;
    got.x = out_sample_x;
    got.y = out_sample_y;
    got.z = out_sample_z;
    got.run_end = out_run_end;
    got.curve_end = out_curve_end;
    if (pending_samples.size() == 0) begin
      if (mismatch_count < MAX_REPORTS)
        $display("unexpected sample x=%0d y=%0d z=%0d run_end=%0b curve_end=%0b",
                 got.x, got.y, got.z, got.run_end, got.curve_end);
      mismatch_count++;
      return;
    end
    want = pending_samples.pop_front();
    if (got !== want) begin
      if (mismatch_count < MAX_REPORTS) begin
        $display("sample mismatch: expected x=%0d y=%0d z=%0d run_end=%0b curve_end=%0b",
                 want.x, want.y, want.z, want.run_end, want.curve_end);
        $display("                 got      x=%0d y=%0d z=%0d run_end=%0b curve_end=%0b",
                 got.x, got.y, got.z, got.run_end, got.curve_end);
      end
      mismatch_count++;
    end
  endfunction

  // sample sink: per-item stall draw, plus long holds requested by the tests
  initial begin : sample_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        check_sample();
        stall_left = no_gaps ? 0 : $urandom_range(0, 4);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[catmull_rom_curve_tessellator_core] ERROR");
    $finish;
  end

  // reset count: single point, two-point, overshoot and bit-pattern curves
  task automatic test_reset_count_curves();
    send_point(mk_point(C_MAX, C_MIN, '0), 1'b1);
    send_point(mk_point(C_MIN, C_MAX, '1), 1'b0);
    send_point(mk_point(C_MAX, C_MIN, '0), 1'b1);
    // swings that push the spline past the coordinate range
    send_point(mk_point(C_MIN, C_MIN, C_MIN), 1'b0);
    send_point(mk_point(C_MAX, C_MAX, '0), 1'b0);
    send_point(mk_point(C_MAX, C_MAX, '0), 1'b0);
    send_point(mk_point(C_MIN, C_MIN, C_MIN), 1'b1);
    send_point(mk_point(24'h555555, 24'hAAAAAA, 24'h000001), 1'b0);
    send_point(mk_point(24'hAAAAAA, 24'h555555, -2), 1'b0);
    send_point(mk_point('0, '0, '0), 1'b1);
  endtask

  // count below two, above the maximum, and a change in the middle of a curve
  task automatic test_sample_count_limits();
    write_sample_count('0);
    send_point(mk_point(100, -300, 7), 1'b0);
    send_point(mk_point(-1001, 255, 4096), 1'b0);
    send_point(mk_point(3, 3, -3), 1'b1);
    write_sample_count(6'd1);
    send_point(mk_point(C_MIN, 1, C_MAX), 1'b0);
    send_point(mk_point(C_MAX, -1, C_MIN), 1'b1);
    write_sample_count('1);
    send_point(mk_point(-5000, 1234, 77), 1'b0);
    send_point(mk_point(9000, -4321, -77), 1'b1);
    write_sample_count(6'd2);
    send_point(mk_point(0, 0, 0), 1'b0);
    send_point(mk_point(256, -256, 513), 1'b0);
    send_point(mk_point(-512, 1023, -1), 1'b0);
    write_sample_count(6'd7);
    send_point(mk_point(2000, 2000, 2000), 1'b0);
    send_point(mk_point(-3, 4, -5), 1'b1);
  endtask

  // output held off for a long stretch while points keep coming
  task automatic test_output_hold();
    write_sample_count(6'd4);
    hold_cycles = 400;
    for (int i = 0; i < 12; i++)
      send_point(mk_point(rand_coord(), rand_coord(), rand_coord()), i == 11);
  endtask

  task automatic test_random_curves();
    int     sent, phase_items, left_in_curve, pick, phase;
    logic [CFG_W-1:0] cnt;
    bit     smooth;
    point_t cur;
    sent = 0;
    left_in_curve = 0;
    phase = 0;
    cur = '0;
    smooth = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) cnt = CFG_W'($urandom_range(2, 8));
      else if (pick == 7) cnt = CFG_W'($urandom_range(0, 1));
      else if (pick == 8) cnt = CFG_W'($urandom_range(9, 31));
      else cnt = CFG_W'($urandom_range(32, 63));
      write_sample_count(cnt);
      no_gaps = (phase == 1) || ($urandom_range(0, 5) == 0);
      phase_items = (cnt >= 16) ? $urandom_range(6, 12) : $urandom_range(20, 40);
      // phases end wherever they end, so some counts change in the middle of a curve
      repeat (phase_items) begin
        if (left_in_curve == 0) begin
          pick = $urandom_range(0, 19);
          if (pick < 3) left_in_curve = 1;
          else if (pick < 16) left_in_curve = $urandom_range(2, 6);
          else left_in_curve = $urandom_range(7, 24);
          smooth = ($urandom_range(0, 1) == 1);
          cur = mk_point(rand_coord(), rand_coord(), rand_coord());
        end else if (smooth) begin
          cur.x = coord_t'(cur.x + coord_t'($urandom_range(0, 4000)) - 2000);
          cur.y = coord_t'(cur.y + coord_t'($urandom_range(0, 4000)) - 2000);
          cur.z = coord_t'(cur.z + coord_t'($urandom_range(0, 4000)) - 2000);
        end else begin
          cur = mk_point(rand_coord(), rand_coord(), rand_coord());
        end
        send_point(cur, left_in_curve == 1);
        left_in_curve--;
        sent++;
      end
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_count_curves();
    test_sample_count_limits();
    test_output_hold();
    test_random_curves();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_samples.size() == 0)
      $display("[catmull_rom_curve_tessellator_core] OK");
    else
      $display("[catmull_rom_curve_tessellator_core] ERROR");
    $finish;
  end

endmodule

### files.f
sv/crtess_pkg.sv
sv/crtess_dp.sv
sv/crtess_ctrl.sv
sv/catmull_rom_curve_tessellator_core.sv
sv/crtess_checker.sv
sim/tb_top.sv
